### rtl/core/rgb_to_hsv_converter_macros.svh
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_macros
// assertion macros used by the rgb to hsv converter rtl
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold at every clock edge out of reset
`define RHC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rhc assertion failed");

// antecedent implies consequent in the same cycle
`define RHC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhc assertion failed");

`else

`define RHC_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define RHC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// shared types and constants of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHAN_WIDTH   = 8;
    localparam int HUE_WIDTH    = 15;
    localparam int SAT_WIDTH    = 16;

    // both divisions run on a 24 bit numerator and an 8 bit divisor
    localparam int DIV_NUM_WIDTH = 24;
    localparam int DIV_STEPS_PER_STAGE = 4;

    localparam logic [HUE_WIDTH-1:0] HUE_SECTOR = 15'd3840;
    localparam logic [HUE_WIDTH-1:0] HUE_BASE_GREEN = 15'd7680;
    localparam logic [HUE_WIDTH-1:0] HUE_BASE_BLUE = 15'd15360;
    localparam logic [HUE_WIDTH-1:0] HUE_FULL = 15'd23040;

    localparam logic [SAT_WIDTH-1:0] GREY_THRESHOLD_RESET = 16'd9830;
    localparam logic [SAT_WIDTH-1:0] SAT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // per item side data carried alongside the dividers
    typedef struct packed {
        sector_t                 sector;
        logic                    neg;
        logic                    span_zero;
        logic                    max_zero;
        logic [CHAN_WIDTH-1:0]   brightness;
    } side_t;

endpackage

### rtl/core/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// input capture, max/min search and divider operand setup, three stages
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [rhc_pkg::CHAN_WIDTH-1:0]    red,
    input  logic [rhc_pkg::CHAN_WIDTH-1:0]    green,
    input  logic [rhc_pkg::CHAN_WIDTH-1:0]    blue,
    output logic                              out_valid,
    output rhc_pkg::side_t                    side,
    output logic [rhc_pkg::DIV_NUM_WIDTH-1:0] hue_num,
    output logic [rhc_pkg::DIV_NUM_WIDTH-1:0] sat_num,
    output logic [rhc_pkg::CHAN_WIDTH-1:0]    span,
    output logic [rhc_pkg::CHAN_WIDTH-1:0]    max_chan
);

    localparam int CW = rhc_pkg::CHAN_WIDTH;
    localparam int NW = rhc_pkg::DIV_NUM_WIDTH;

    // stage 0: input capture
    logic          v0_reg;
    logic [CW-1:0] r0_reg, g0_reg, b0_reg;

    // stage 1: max, min and sector
    logic          v1_reg, v1_next;
    logic [CW-1:0] r1_reg, g1_reg, b1_reg;
    logic [CW-1:0] max1_reg, max1_next, min1_reg, min1_next;
    rhc_pkg::sector_t sect1_reg, sect1_next;

    // stage 2: operands
    logic          v2_reg;
    rhc_pkg::side_t side2_reg, side2_next;
    logic [NW-1:0] hue_num2_reg, hue_num2_next, sat_num2_reg, sat_num2_next;
    logic [CW-1:0] span2_reg, span2_next, max2_reg;

    logic [CW:0]   diff;
    logic [CW:0]   mag_full;
    logic [CW-1:0] mag;

    assign v1_next = v0_reg;

    always_comb
    begin
        // ties go to red, then green
        if (r0_reg >= g0_reg && r0_reg >= b0_reg)
        begin
            sect1_next = rhc_pkg::SECT_RED;
            max1_next  = r0_reg;
        end
        else if (g0_reg >= b0_reg)
        begin
            sect1_next = rhc_pkg::SECT_GREEN;
            max1_next  = g0_reg;
        end
        else
        begin
            sect1_next = rhc_pkg::SECT_BLUE;
            max1_next  = b0_reg;
        end
        min1_next = r0_reg;
        if (g0_reg < min1_next)
            min1_next = g0_reg;
        if (b0_reg < min1_next)
            min1_next = b0_reg;
    end

    always_comb
    begin
        unique case (sect1_reg)
            rhc_pkg::SECT_RED:   diff = {1'b0, g1_reg} - {1'b0, b1_reg};
            rhc_pkg::SECT_GREEN: diff = {1'b0, b1_reg} - {1'b0, r1_reg};
            rhc_pkg::SECT_BLUE:  diff = {1'b0, r1_reg} - {1'b0, g1_reg};
            default:             diff = '0;
        endcase
        mag_full = diff[CW] ? (~diff + 1'b1) : diff;
        mag      = mag_full[CW-1:0];

        span2_next    = max1_reg - min1_reg;
        hue_num2_next = NW'(mag) * NW'(rhc_pkg::HUE_SECTOR);
        sat_num2_next = {span2_next, 16'h0000};

        side2_next.sector     = sect1_reg;
        side2_next.neg        = diff[CW];
        side2_next.span_zero  = (span2_next == '0);
        side2_next.max_zero   = (max1_reg == '0);
        side2_next.brightness = max1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg       <= red;
        g0_reg       <= green;
        b0_reg       <= blue;
        r1_reg       <= r0_reg;
        g1_reg       <= g0_reg;
        b1_reg       <= b0_reg;
        max1_reg     <= max1_next;
        min1_reg     <= min1_next;
        sect1_reg    <= sect1_next;
        side2_reg    <= side2_next;
        hue_num2_reg <= hue_num2_next;
        sat_num2_reg <= sat_num2_next;
        span2_reg    <= span2_next;
        max2_reg     <= max1_reg;
    end

    assign out_valid = v2_reg;
    assign side      = side2_reg;
    assign hue_num   = hue_num2_reg;
    assign sat_num   = sat_num2_reg;
    assign span      = span2_reg;
    assign max_chan  = max2_reg;

endmodule

### rtl/core/rhc_divider.sv
// ----------------------------------------------------------------------------
// rhc_divider
// pipelined restoring divider, STEPS_PER_STAGE quotient bits per stage
// ----------------------------------------------------------------------------
module rhc_divider #(
    parameter int NUM_WIDTH       = rhc_pkg::DIV_NUM_WIDTH,
    parameter int DEN_WIDTH       = rhc_pkg::CHAN_WIDTH,
    parameter int STEPS_PER_STAGE = rhc_pkg::DIV_STEPS_PER_STAGE
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [DEN_WIDTH-1:0] den,
    output logic                 out_valid,
    output logic [NUM_WIDTH-1:0] quot,
    output logic [DEN_WIDTH-1:0] rem
);

    localparam int STAGES = (NUM_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // work holds the unconsumed numerator bits, quotient bits shift in at the bottom
    logic                 valid_reg [STAGES];
    logic [NUM_WIDTH-1:0] work_reg  [STAGES];
    logic [DEN_WIDTH-1:0] rem_reg   [STAGES];
    logic [DEN_WIDTH-1:0] den_reg   [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic                 valid_in;
        logic [NUM_WIDTH-1:0] work_in, work_next;
        logic [DEN_WIDTH-1:0] rem_in, rem_next, den_in;

        if (s == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign work_in  = num;
            assign rem_in   = '0;
            assign den_in   = den;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[s-1];
            assign work_in  = work_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign den_in   = den_reg[s-1];
        end

        always_comb
        begin
            logic [DEN_WIDTH:0] trial;
            work_next = work_in;
            rem_next  = rem_in;
            trial     = '0;
            for (int k = 0; k < STEPS_PER_STAGE; k++)
            begin
                if (s * STEPS_PER_STAGE + k < NUM_WIDTH)
                begin
                    trial     = {rem_next, work_next[NUM_WIDTH-1]};
                    work_next = {work_next[NUM_WIDTH-2:0], 1'b0};
                    if (trial >= {1'b0, den_in})
                    begin
                        trial        = trial - {1'b0, den_in};
                        work_next[0] = 1'b1;
                    end
                    rem_next = trial[DEN_WIDTH-1:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            work_reg[s] <= work_next;
            rem_reg[s]  <= rem_next;
            den_reg[s]  <= den_in;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quot      = work_reg[STAGES-1];
    assign rem       = rem_reg[STAGES-1];

endmodule

### rtl/core/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// 8-bit rgb pixel to fixed point hue, saturation, value and grey flag
// ----------------------------------------------------------------------------
// fully pipelined: one item is taken in every clock cycle and busy never rises.
// each item's result appears on the result ports, marked by result_valid, for
// one cycle; the receiver cannot stall, so results must be taken as they come.
// each item passes the front end stages, the stages of the two restoring
// dividers (hue offset and saturation), which retire STEPS_PER_STAGE quotient
// bits per stage, and the result register. grey_threshold is written through
// the cfg port (always ready) and should only change while no item is in flight.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter #(
    parameter int STEPS_PER_STAGE = rhc_pkg::DIV_STEPS_PER_STAGE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // item input
    input  logic                            start,
    output logic                            busy,
    input  logic [rhc_pkg::CHAN_WIDTH-1:0]  red,
    input  logic [rhc_pkg::CHAN_WIDTH-1:0]  green,
    input  logic [rhc_pkg::CHAN_WIDTH-1:0]  blue,
    // result output
    output logic                            result_valid,
    output logic [rhc_pkg::HUE_WIDTH-1:0]   hue,
    output logic [rhc_pkg::SAT_WIDTH-1:0]   saturation,
    output logic [rhc_pkg::CHAN_WIDTH-1:0]  brightness,
    output logic                            is_grey,
    // configuration write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rhc_pkg::SAT_WIDTH-1:0]   cfg_data
);

    localparam int NW       = rhc_pkg::DIV_NUM_WIDTH;
    localparam int CW       = rhc_pkg::CHAN_WIDTH;
    localparam int HW       = rhc_pkg::HUE_WIDTH;
    localparam int SW       = rhc_pkg::SAT_WIDTH;
    localparam int STAGES   = (NW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int LATENCY  = STAGES + 4;
    // hue quotient never exceeds 3840, so 12 bits carry it
    localparam int HQ_WIDTH = 12;

    logic [SW-1:0] threshold_reg;

    // front end outputs
    logic           fe_valid;
    rhc_pkg::side_t fe_side;
    logic [NW-1:0]  fe_hue_num, fe_sat_num;
    logic [CW-1:0]  fe_span, fe_max;

    // divider outputs
    logic          hdiv_valid, sdiv_valid;
    logic [NW-1:0] hdiv_quot, sdiv_quot;
    logic [CW-1:0] hdiv_rem, sdiv_rem;

    // side data delayed to line up with the divider outputs
    rhc_pkg::side_t side_reg [STAGES];
    rhc_pkg::side_t side_out;

    // result stage
    logic          valid_reg;
    logic [HW-1:0] hue_reg, hue_next;
    logic [SW-1:0] sat_reg, sat_next;
    logic [CW-1:0] bright_reg;
    logic          grey_reg, grey_next;

    logic [HQ_WIDTH-1:0] hq;
    logic [HQ_WIDTH:0]   hq_ceil;
    logic [HW-1:0]       hue_base;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= rhc_pkg::GREY_THRESHOLD_RESET;
        else if (cfg_valid && cfg_ready)
            threshold_reg <= cfg_data;
    end

    rhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (fe_valid),
        .side      (fe_side),
        .hue_num   (fe_hue_num),
        .sat_num   (fe_sat_num),
        .span      (fe_span),
        .max_chan  (fe_max)
    );

    // hue offset: 3840 * |diff| / span
    rhc_divider #(
        .NUM_WIDTH       (NW),
        .DEN_WIDTH       (CW),
        .STEPS_PER_STAGE (STEPS_PER_STAGE)
    ) u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .num       (fe_hue_num),
        .den       (fe_span),
        .out_valid (hdiv_valid),
        .quot      (hdiv_quot),
        .rem       (hdiv_rem)
    );

    // saturation: span * 65536 / max
    rhc_divider #(
        .NUM_WIDTH       (NW),
        .DEN_WIDTH       (CW),
        .STEPS_PER_STAGE (STEPS_PER_STAGE)
    ) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .num       (fe_sat_num),
        .den       (fe_max),
        .out_valid (sdiv_valid),
        .quot      (sdiv_quot),
        .rem       (sdiv_rem)
    );

    for (genvar s = 0; s < STAGES; s++)
    begin : g_side
        if (s == 0)
        begin : g_first
            always_ff @(posedge clk)
                side_reg[s] <= fe_side;
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
                side_reg[s] <= side_reg[s-1];
        end
    end

    assign side_out = side_reg[STAGES-1];

    // result assembly
    always_comb
    begin
        hq      = hdiv_quot[HQ_WIDTH-1:0];
        // negative differences round toward minus infinity: negate the ceiling
        hq_ceil = {1'b0, hq} + (HQ_WIDTH + 1)'(hdiv_rem != '0);

        unique case (side_out.sector)
            rhc_pkg::SECT_RED:   hue_base = '0;
            rhc_pkg::SECT_GREEN: hue_base = rhc_pkg::HUE_BASE_GREEN;
            rhc_pkg::SECT_BLUE:  hue_base = rhc_pkg::HUE_BASE_BLUE;
            default:             hue_base = '0;
        endcase

        if (side_out.span_zero)
            hue_next = '0;
        else if (side_out.neg)
        begin
            // red sector wraps below zero to the top of the circle
            if (side_out.sector == rhc_pkg::SECT_RED)
                hue_next = rhc_pkg::HUE_FULL - HW'(hq_ceil);
            else
                hue_next = hue_base - HW'(hq_ceil);
        end
        else
            hue_next = hue_base + HW'(hq);

        // full span gives 65536, clamp it
        if (side_out.max_zero)
            sat_next = '0;
        else if (sdiv_quot[NW-1:SW] != '0)
            sat_next = rhc_pkg::SAT_MAX;
        else
            sat_next = sdiv_quot[SW-1:0];

        grey_next = (sat_next < threshold_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= hdiv_valid;
    end

    always_ff @(posedge clk)
    begin
        hue_reg    <= hue_next;
        sat_reg    <= sat_next;
        bright_reg <= side_out.brightness;
        grey_reg   <= grey_next;
    end

    assign result_valid = valid_reg;
    assign hue          = hue_reg;
    assign saturation   = sat_reg;
    assign brightness   = bright_reg;
    assign is_grey      = grey_reg;

    // both dividers move in lockstep
    `RHC_ASSERT_ALWAYS(a_div_lockstep, clk, rst_n, hdiv_valid == sdiv_valid)
    // every result comes a fixed latency after its start
    `RHC_ASSERT_IMPLIES(a_latency, clk, rst_n, result_valid, $past(start && rst_n, LATENCY))
    // hue stays on the circle
    `RHC_ASSERT_IMPLIES(a_hue_range, clk, rst_n, result_valid, hue < rhc_pkg::HUE_FULL)
    // a black pixel has no hue and no saturation
    `RHC_ASSERT_IMPLIES(a_black, clk, rst_n, result_valid && brightness == '0, hue == '0 && saturation == '0)

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the rgb to hsv converter: a directed pixel table and
// then about a thousand random pixels over several grey thresholds, each
// result checked against a typed expectation or an in-bench hsv calculation
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CHAN_WIDTH = rhc_pkg::CHAN_WIDTH;
    localparam int HUE_WIDTH  = rhc_pkg::HUE_WIDTH;
    localparam int SAT_WIDTH  = rhc_pkg::SAT_WIDTH;

    // fixed point hue constants, kept as signed ints for the offset math
    localparam int HUE_STEP  = 3840;
    localparam int HUE_WRAP  = 23040;
    localparam int BASE_GRN  = 7680;
    localparam int BASE_BLU  = 15360;

    // pipeline depth of the converter at its default settings, plus some margin
    localparam int LATENCY   = 10;
    localparam int SETTLE    = LATENCY + 10;
    // cycles with no handshake of any kind before the run is called hung
    localparam int QUIET_MAX = 2000;
    localparam int RAND_PER_SETTING = 165;
    localparam int NUM_ROWS  = 20;

    // one expected result
    typedef struct packed {
        logic [HUE_WIDTH-1:0]  hue;
        logic [SAT_WIDTH-1:0]  sat;
        logic [CHAN_WIDTH-1:0] bri;
        logic                  grey;
    } hsv_t;

    // one row of the directed pixel table
    typedef struct packed {
        logic [CHAN_WIDTH-1:0] r;
        logic [CHAN_WIDTH-1:0] g;
        logic [CHAN_WIDTH-1:0] b;
        logic                  known;  // expected result typed in below
        hsv_t                  want;
    } pixel_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [CHAN_WIDTH-1:0] red;
    logic [CHAN_WIDTH-1:0] green;
    logic [CHAN_WIDTH-1:0] blue;
    logic                  result_valid;
    logic [HUE_WIDTH-1:0]  hue;
    logic [SAT_WIDTH-1:0]  saturation;
    logic [CHAN_WIDTH-1:0] brightness;
    logic                  is_grey;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SAT_WIDTH-1:0]  cfg_data;

    // bench copy of the threshold register
    logic [SAT_WIDTH-1:0]  grey_limit;

    // expectation attached to the item now on the pins, for typed table rows
    logic                  item_known;
    hsv_t                  item_want;

    hsv_t                  hsv_pending[$];
    int                    mismatch_count;
    int                    quiet_cycles;

    rgb_to_hsv_converter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .result_valid (result_valid),
        .hue          (hue),
        .saturation   (saturation),
        .brightness   (brightness),
        .is_grey      (is_grey),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // hsv calculation: max channel picks the sector, red wins ties, then green
    // ------------------------------------------------------------------------
    function automatic hsv_t hsv_of(input logic [CHAN_WIDTH-1:0] r,
                                    input logic [CHAN_WIDTH-1:0] g,
                                    input logic [CHAN_WIDTH-1:0] b,
                                    input logic [SAT_WIDTH-1:0]  limit);
        hsv_t             res;
        rhc_pkg::sector_t sect;
        int               ri;
        int               gi;
        int               bi;
        int               mx;
        int               mn;
        int               span;
        int               base;
        int               diff;
        int               num;
        int               off;
        int               hue_i;
        int               sat_i;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        if (ri >= gi && ri >= bi)
        begin
            sect = rhc_pkg::SECT_RED;
            mx   = ri;
        end
        else if (gi >= bi)
        begin
            sect = rhc_pkg::SECT_GREEN;
            mx   = gi;
        end
        else
        begin
            sect = rhc_pkg::SECT_BLUE;
            mx   = bi;
        end
        mn = ri;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        span = mx - mn;

        case (sect)
            rhc_pkg::SECT_RED:
            begin
                base = 0;
                diff = gi - bi;
            end
            rhc_pkg::SECT_GREEN:
            begin
                base = BASE_GRN;
                diff = bi - ri;
            end
            default:
            begin
                base = BASE_BLU;
                diff = ri - gi;
            end
        endcase

        hue_i = 0;
        if (span > 0)
        begin
            // integer divide truncates toward zero; step down for a true floor
            num = HUE_STEP * diff;
            off = num / span;
            if (num < 0 && (num % span) != 0)
                off = off - 1;
            hue_i = base + off;
            if (hue_i < 0)
                hue_i = hue_i + HUE_WRAP;
        end

        sat_i = 0;
        if (mx > 0)
        begin
            sat_i = (span << 16) / mx;
            if (sat_i > 65535)
                sat_i = 65535;
        end

        res.hue  = HUE_WIDTH'(hue_i);
        res.sat  = SAT_WIDTH'(sat_i);
        res.bri  = CHAN_WIDTH'(mx);
        res.grey = (SAT_WIDTH'(sat_i) < limit);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // one process for every handshake: results first, then new items, so the
    // expectation queue never sees a push and a pop race within one edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        hsv_t exp_hsv;
        bit   moved;
        moved = 1'b0;
        if (rst_n)
        begin
            // result side: the strobe lasts one cycle, no back pressure
            if (result_valid === 1'b1)
            begin
                moved = 1'b1;
                if (hsv_pending.size() == 0)
                begin
                    $error("result with no item outstanding: hue %0d sat %0d",
                           hue, saturation);
                    mismatch_count++;
                end
                else
                begin
                    exp_hsv = hsv_pending.pop_front();
                    if (hue !== exp_hsv.hue)
                    begin
                        $error("hue mismatch: expected %0d, got %0d", exp_hsv.hue, hue);
                        mismatch_count++;
                    end
                    if (saturation !== exp_hsv.sat)
                    begin
                        $error("saturation mismatch: expected %0d, got %0d",
                               exp_hsv.sat, saturation);
                        mismatch_count++;
                    end
                    if (brightness !== exp_hsv.bri)
                    begin
                        $error("brightness mismatch: expected %0d, got %0d",
                               exp_hsv.bri, brightness);
                        mismatch_count++;
                    end
                    if (is_grey !== exp_hsv.grey)
                    begin
                        $error("is_grey mismatch: expected %0b, got %0b",
                               exp_hsv.grey, is_grey);
                        mismatch_count++;
                    end
                end
            end

            // item side: typed table rows carry their own expectation
            if (start && busy === 1'b0)
            begin
                moved = 1'b1;
                if (item_known)
                    hsv_pending.push_back(item_want);
                else
                    hsv_pending.push_back(hsv_of(red, green, blue, grey_limit));
            end

            // threshold write only ever happens with the pipe empty
            if (cfg_valid && cfg_ready === 1'b1)
            begin
                moved = 1'b1;
                grey_limit = cfg_data;
            end
        end

        // watchdog on handshake activity
        if (moved || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap(input bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one pixel from a falling edge and hold it until taken
    task automatic send_pixel(input logic [CHAN_WIDTH-1:0] r,
                              input logic [CHAN_WIDTH-1:0] g,
                              input logic [CHAN_WIDTH-1:0] b,
                              input logic known,
                              input hsv_t want,
                              input int gap);
        @(negedge clk);
        start      <= 1'b1;
        red        <= r;
        green      <= g;
        blue       <= b;
        item_known  = known;
        item_want   = want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // idle cycles after the item; with no gap start stays high
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            red   <= CHAN_WIDTH'($urandom);
            green <= CHAN_WIDTH'($urandom);
            blue  <= CHAN_WIDTH'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_pipe;
        @(negedge clk);
        start <= 1'b0;
        while (hsv_pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_grey_limit(input logic [SAT_WIDTH-1:0] value);
        drain_pipe();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random pixel shaped toward the interesting corners of the hsv space
    task automatic random_pixel(output logic [CHAN_WIDTH-1:0] r,
                                output logic [CHAN_WIDTH-1:0] g,
                                output logic [CHAN_WIDTH-1:0] b);
        int mode;
        int lvl;
        mode = $urandom_range(0, 9);
        r = CHAN_WIDTH'($urandom);
        g = CHAN_WIDTH'($urandom);
        b = CHAN_WIDTH'($urandom);
        case (mode)
            // near grey: green and blue up to six counts above red, wrapping past 255
            0, 1:
            begin
                lvl = $urandom_range(0, 255);
                r = CHAN_WIDTH'(lvl);
                g = CHAN_WIDTH'((lvl + $urandom_range(0, 6)) % 256);
                b = CHAN_WIDTH'((lvl + $urandom_range(0, 6)) % 256);
            end
            // ties on the largest channel
            2:
            begin
                lvl = $urandom_range(1, 255);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        r = CHAN_WIDTH'(lvl);
                        g = CHAN_WIDTH'(lvl);
                    end
                    1:
                    begin
                        g = CHAN_WIDTH'(lvl);
                        b = CHAN_WIDTH'(lvl);
                    end
                    2:
                    begin
                        r = CHAN_WIDTH'(lvl);
                        b = CHAN_WIDTH'(lvl);
                    end
                    default:
                    begin
                        r = CHAN_WIDTH'(lvl);
                        g = CHAN_WIDTH'(lvl);
                        b = CHAN_WIDTH'(lvl);
                    end
                endcase
                if (r > CHAN_WIDTH'(lvl)) r = CHAN_WIDTH'(lvl);
                if (g > CHAN_WIDTH'(lvl)) g = CHAN_WIDTH'(lvl);
                if (b > CHAN_WIDTH'(lvl)) b = CHAN_WIDTH'(lvl);
            end
            // red pinned to a rail, green and blue now and then
            3:
            begin
                if ($urandom_range(0, 1) == 1) r = '0; else r = '1;
                if ($urandom_range(0, 2) == 0) g = '1;
                if ($urandom_range(0, 2) == 0) b = '0;
            end
            // a zero channel gives full span and saturated saturation
            4:
            begin
                case ($urandom_range(0, 2))
                    0: r = '0;
                    1: g = '0;
                    default: b = '0;
                endcase
            end
            // dark pixels, small max makes the divide coarse
            5:
            begin
                r = CHAN_WIDTH'($urandom_range(0, 3));
                g = CHAN_WIDTH'($urandom_range(0, 3));
                b = CHAN_WIDTH'($urandom_range(0, 3));
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // directed rows; typed expectations hold for the reset threshold
    // ------------------------------------------------------------------------
    pixel_row_t pixel_rows [NUM_ROWS] = '{
        // black and white: no span, no saturation, grey
        '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     16'd0,     8'd0,   1'b1}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     16'd0,     8'd255, 1'b1}},
        // primaries, full span saturates
        '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     16'd65535, 8'd255, 1'b0}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  16'd65535, 8'd255, 1'b0}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 16'd65535, 8'd255, 1'b0}},
        // ties: red beats green and blue, green beats blue
        '{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  16'd65535, 8'd255, 1'b0}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 16'd65535, 8'd255, 1'b0}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 16'd65535, 8'd255, 1'b0}},
        // smallest nonzero pixel at full span and flat, then a mid grey
        '{8'd1,   8'd0,   8'd0,   1'b1, '{15'd0,     16'd65535, 8'd1,   1'b0}},
        '{8'd1,   8'd1,   8'd1,   1'b1, '{15'd0,     16'd0,     8'd1,   1'b1}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     16'd0,     8'd128, 1'b1}},
        // red sector wraps near the top, then mixed rows left to the calculation
        '{8'd255, 8'd0,   8'd1,   1'b0, '0},
        '{8'd200, 8'd10,  8'd100, 1'b0, '0},
        '{8'd255, 8'd254, 8'd254, 1'b0, '0},
        '{8'd100, 8'd100, 8'd99,  1'b0, '0},
        '{8'd128, 8'd64,  8'd32,  1'b0, '0},
        '{8'd10,  8'd20,  8'd30,  1'b0, '0},
        '{8'd30,  8'd20,  8'd10,  1'b0, '0},
        '{8'd2,   8'd1,   8'd3,   1'b0, '0},
        '{8'd170, 8'd85,  8'd254, 1'b0, '0}
    };

    // threshold settings walked by the random part, extremes included
    logic [SAT_WIDTH-1:0] limit_plan [6];

    initial
    begin
        logic [CHAN_WIDTH-1:0] r;
        logic [CHAN_WIDTH-1:0] g;
        logic [CHAN_WIDTH-1:0] b;
        bit                    steady;
        rst_n          = 1'b0;
        start          = 1'b0;
        red            = '0;
        green          = '0;
        blue           = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        item_known     = 1'b0;
        item_want      = '0;
        grey_limit     = rhc_pkg::GREY_THRESHOLD_RESET;
        mismatch_count = 0;
        quiet_cycles   = 0;

        limit_plan[0] = 16'd0;
        limit_plan[1] = rhc_pkg::SAT_MAX;
        limit_plan[2] = 16'd1;
        limit_plan[3] = 16'd32768;
        limit_plan[4] = SAT_WIDTH'($urandom);
        limit_plan[5] = rhc_pkg::GREY_THRESHOLD_RESET;

        // single reset at the start of the run
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table at the reset threshold
        foreach (pixel_rows[i])
            send_pixel(pixel_rows[i].r, pixel_rows[i].g, pixel_rows[i].b,
                       pixel_rows[i].known, pixel_rows[i].want,
                       pick_gap(i < NUM_ROWS / 2));

        // random pixels under each threshold; every write waits for an empty
        // pipe, so the sender pauses for all results before each one
        foreach (limit_plan[p])
        begin
            set_grey_limit(limit_plan[p]);
            steady = 1'b0;
            for (int n = 0; n < RAND_PER_SETTING; n++)
            begin
                // bursts with no idling at all mixed with gappy stretches
                if (n % 32 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                random_pixel(r, g, b);
                send_pixel(r, g, b, 1'b0, '0, pick_gap(steady));
            end
        end

        drain_pipe();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && hsv_pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rhc_pkg.sv
rtl/core/rhc_front.sv
rtl/core/rhc_divider.sv
rtl/core/rgb_to_hsv_converter.sv
dv/tb_top.sv
